### rtl/trls_pkg.sv
// ----------------------------------------------------------------------------
// trls_pkg: shared types and constants of the two-road light sequencer
// Phase and lamp codes, field widths, the buzzer settings and the reset times.
// ----------------------------------------------------------------------------
package trls_pkg;

    // field widths
    localparam int TIME_W   = 7;
    localparam int COUNT_W  = 8;
    localparam int PERIOD_W = 10;
    localparam int VOLUME_W = 7;
    localparam int CFG_IDX_W = 2;

    // controller phase
    typedef enum logic [2:0] {
        PH_INIT = 3'd0,
        PH_LOAD = 3'd1,
        PH_RG   = 3'd2,
        PH_RA   = 3'd3,
        PH_GR   = 3'd4,
        PH_AR   = 3'd5
    } t_phase;

    // lamp color of one road
    typedef enum logic [1:0] {
        LAMP_RED   = 2'd0,
        LAMP_AMBER = 2'd1,
        LAMP_GREEN = 2'd2,
        LAMP_OFF   = 2'd3
    } t_lamp;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RED_TIME   = 2'd0,
        CFG_GREEN_TIME = 2'd1,
        CFG_AMBER_TIME = 2'd2,
        CFG_UNUSED     = 2'd3
    } t_cfg_idx;

    // buzzer settings
    localparam logic [PERIOD_W-1:0] BUZZ_LOAD_PERIOD  = 10'd400;
    localparam logic [VOLUME_W-1:0] BUZZ_LOAD_VOLUME  = 7'd15;
    localparam logic [PERIOD_W-1:0] BUZZ_AMBER_PERIOD = 10'd75;
    localparam logic [VOLUME_W-1:0] BUZZ_AMBER_VOLUME = 7'd100;
    localparam logic [PERIOD_W-1:0] BUZZ_WARN_PERIOD  = 10'd200;
    localparam logic [VOLUME_W-1:0] BUZZ_WARN_VOLUME  = 7'd50;
    localparam logic [PERIOD_W-1:0] BUZZ_GREEN_PERIOD = 10'd500;
    localparam logic [VOLUME_W-1:0] BUZZ_GREEN_VOLUME = 7'd20;

    // reset values of the time registers
    localparam logic [TIME_W-1:0] RED_TIME_RST   = 7'd5;
    localparam logic [TIME_W-1:0] GREEN_TIME_RST = 7'd3;
    localparam logic [TIME_W-1:0] AMBER_TIME_RST = 7'd2;

endpackage

### rtl/two_road_light_sequencer_core.sv
// ----------------------------------------------------------------------------
// two_road_light_sequencer_core: automatic two-road traffic light controller
// Steps through init, load and the four light phases, one request per step,
// with per-road countdowns and a phase-driven buzzer setting.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | i_in_valid, o_in_stall, i_second_tick    | request in
//  out     | o_out_valid, i_out_stall, o_phase_code.. | result out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data        | write only
//
//  one request per clock unless stalled; its result is valid the cycle after
//  acceptance. the state registers are the result register: the next request
//  is taken at the same edge at which the waiting result is taken.
//  synchronous active-low reset puts the phase in init with zero counts.
//  a stall on a waiting result stalls the request side in the same cycle.
// ----------------------------------------------------------------------------
module two_road_light_sequencer_core
    import trls_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // request channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_second_tick,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [2:0]                 o_phase_code,
    output logic [1:0]                 o_road1_light,
    output logic [1:0]                 o_road2_light,
    output logic signed [COUNT_W-1:0]  o_road1_seconds,
    output logic signed [COUNT_W-1:0]  o_road2_seconds,
    output logic [PERIOD_W-1:0]        o_buzz_period,
    output logic [VOLUME_W-1:0]        o_buzz_volume,
    // configuration port
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [TIME_W-1:0]          i_cfg_data
);

    // configuration registers
    logic [TIME_W-1:0]   r_red_time, r_green_time, r_amber_time;

    // controller state, shown directly as the result
    t_phase              r_phase, n_phase;
    logic [COUNT_W-1:0]  r_cnt1, n_cnt1;
    logic [COUNT_W-1:0]  r_cnt2, n_cnt2;
    logic [PERIOD_W-1:0] r_period, n_period;
    logic [VOLUME_W-1:0] r_volume, n_volume;
    logic                r_out_valid;

    logic                w_accept;
    logic [COUNT_W-1:0]  w_dec1, w_dec2;
    logic                w_end1, w_end2;
    logic                w_warn;
    t_lamp               w_lamp1, w_lamp2;

    // handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_time   <= RED_TIME_RST;
            r_green_time <= GREEN_TIME_RST;
            r_amber_time <= AMBER_TIME_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RED_TIME:   r_red_time   <= i_cfg_data;
                CFG_GREEN_TIME: r_green_time <= i_cfg_data;
                CFG_AMBER_TIME: r_amber_time <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // countdown decrement and end-of-phase tests
    assign w_dec1 = r_cnt1 - COUNT_W'(1);
    assign w_dec2 = r_cnt2 - COUNT_W'(1);
    assign w_end1 = w_dec1[COUNT_W-1] || (w_dec1 == '0);
    assign w_end2 = w_dec2[COUNT_W-1] || (w_dec2 == '0);
    // second half of green: count at or below green_time / 2
    assign w_warn = $signed(w_dec2) <=
                    $signed({{(COUNT_W-TIME_W+1){1'b0}}, r_green_time[TIME_W-1:1]});

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_cnt1   = r_cnt1;
        n_cnt2   = r_cnt2;
        n_period = r_period;
        n_volume = r_volume;
        unique case (r_phase)
            PH_LOAD: begin
                n_cnt1   = {1'b0, r_red_time};
                n_cnt2   = {1'b0, r_green_time};
                n_period = BUZZ_LOAD_PERIOD;
                n_volume = BUZZ_LOAD_VOLUME;
                n_phase  = PH_RG;
            end
            PH_RG: begin
                if (i_second_tick) begin
                    n_cnt1 = w_dec1;
                    n_cnt2 = w_dec2;
                    if (w_end2) begin
                        n_cnt2   = {1'b0, r_amber_time};
                        n_period = BUZZ_AMBER_PERIOD;
                        n_volume = BUZZ_AMBER_VOLUME;
                        n_phase  = PH_RA;
                    end else if (w_warn) begin
                        n_period = BUZZ_WARN_PERIOD;
                        n_volume = BUZZ_WARN_VOLUME;
                    end
                end
            end
            PH_RA: begin
                if (i_second_tick) begin
                    n_cnt1 = w_dec1;
                    n_cnt2 = w_dec2;
                    if (w_end1) begin
                        n_cnt1  = {1'b0, r_green_time};
                        n_cnt2  = {1'b0, r_red_time};
                        n_phase = PH_GR;
                    end
                end
            end
            PH_GR: begin
                if (i_second_tick) begin
                    n_cnt1 = w_dec1;
                    n_cnt2 = w_dec2;
                    if (w_end1) begin
                        n_cnt1  = {1'b0, r_amber_time};
                        n_phase = PH_AR;
                    end
                end
            end
            PH_AR: begin
                if (i_second_tick) begin
                    n_cnt1 = w_dec1;
                    n_cnt2 = w_dec2;
                    if (w_end1) begin
                        n_cnt1   = {1'b0, r_red_time};
                        n_cnt2   = {1'b0, r_green_time};
                        n_period = BUZZ_GREEN_PERIOD;
                        n_volume = BUZZ_GREEN_VOLUME;
                        n_phase  = PH_RG;
                    end
                end
            end
            // init and unused codes go to load
            default: n_phase = PH_LOAD;
        endcase
    end

    // state register, advanced once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INIT;
            r_cnt1      <= '0;
            r_cnt2      <= '0;
            r_period    <= '0;
            r_volume    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase  <= n_phase;
                r_cnt1   <= n_cnt1;
                r_cnt2   <= n_cnt2;
                r_period <= n_period;
                r_volume <= n_volume;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // lamp decode
    always_comb begin
        w_lamp1 = LAMP_OFF;
        w_lamp2 = LAMP_OFF;
        unique case (r_phase)
            PH_RG: begin w_lamp1 = LAMP_RED;   w_lamp2 = LAMP_GREEN; end
            PH_RA: begin w_lamp1 = LAMP_RED;   w_lamp2 = LAMP_AMBER; end
            PH_GR: begin w_lamp1 = LAMP_GREEN; w_lamp2 = LAMP_RED;   end
            PH_AR: begin w_lamp1 = LAMP_AMBER; w_lamp2 = LAMP_RED;   end
            default: ;
        endcase
    end

    // result outputs
    assign o_out_valid     = r_out_valid;
    assign o_phase_code    = r_phase;
    assign o_road1_light   = w_lamp1;
    assign o_road2_light   = w_lamp2;
    assign o_road1_seconds = $signed(r_cnt1);
    assign o_road2_seconds = $signed(r_cnt2);
    assign o_buzz_period   = r_period;
    assign o_buzz_volume   = r_volume;

    // assertions

    // every accepted request leaves a result behind
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("accepted request produced no result");

    // the state moves only on an accepted request
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_phase) && $stable(r_cnt1) && $stable(r_cnt2))
        else $error("state changed without a request");

    // without a tick red-amber, green-red and amber-red keep their countdowns
    a_no_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_second_tick && (r_phase == PH_RA || r_phase == PH_GR
            || r_phase == PH_AR)) |=> $stable(r_cnt1) && $stable(r_cnt2)
            && $stable(r_phase))
        else $error("countdown moved without a tick");

    // load always leads into red-green with the load buzzer
    a_load_to_rg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == PH_LOAD) |=>
            (r_phase == PH_RG && r_period == BUZZ_LOAD_PERIOD
             && r_volume == BUZZ_LOAD_VOLUME))
        else $error("load phase did not enter red-green");

endmodule

### verif/trls_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trls_checker: lamp and countdown predictor with result scoreboard
// Follows the time registers through the write port and steps its own phase,
// countdown and buzzer state on every accepted request. Each accepted result
// is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module trls_checker
    import trls_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request channel
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic                      i_second_tick,
    // result channel
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [2:0]                i_phase_code,
    input  logic [1:0]                i_road1_light,
    input  logic [1:0]                i_road2_light,
    input  logic signed [COUNT_W-1:0] i_road1_seconds,
    input  logic signed [COUNT_W-1:0] i_road2_seconds,
    input  logic [PERIOD_W-1:0]       i_buzz_period,
    input  logic [VOLUME_W-1:0]       i_buzz_volume,
    // configuration port
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [TIME_W-1:0]         i_cfg_data,
    // status to the testbench top
    output int                        o_err_count,
    output int                        o_open_count
);

    // what the block should show after one step
    typedef struct {
        logic [2:0]          phase;
        t_lamp               road1_lamp;
        t_lamp               road2_lamp;
        logic [COUNT_W-1:0]  road1_secs;
        logic [COUNT_W-1:0]  road2_secs;
        logic [PERIOD_W-1:0] period;
        logic [VOLUME_W-1:0] volume;
    } t_light_view;

    t_light_view lights_due[$];

    // predicted controller state
    t_phase              phase_q;
    logic [COUNT_W-1:0]  road1_cnt;
    logic [COUNT_W-1:0]  road2_cnt;
    logic [PERIOD_W-1:0] buzz_per;
    logic [VOLUME_W-1:0] buzz_vol;
    logic [TIME_W-1:0]   red_s;
    logic [TIME_W-1:0]   green_s;
    logic [TIME_W-1:0]   amber_s;

    int mismatches = 0;
    int pending    = 0;

    assign o_err_count  = mismatches;
    assign o_open_count = pending;

    function automatic void reset_model();
        red_s     = RED_TIME_RST;
        green_s   = GREEN_TIME_RST;
        amber_s   = AMBER_TIME_RST;
        phase_q   = PH_INIT;
        road1_cnt = '0;
        road2_cnt = '0;
        buzz_per  = '0;
        buzz_vol  = '0;
    endfunction

    // one controller step; countdowns are 8 bit two's complement and wrap
    function automatic void take_step(input logic tick);
        int r1;
        int r2;
        if (phase_q == PH_LOAD) begin
            road1_cnt = {1'b0, red_s};
            road2_cnt = {1'b0, green_s};
            buzz_per  = BUZZ_LOAD_PERIOD;
            buzz_vol  = BUZZ_LOAD_VOLUME;
            phase_q   = PH_RG;
        end else if (phase_q inside {PH_RG, PH_RA, PH_GR, PH_AR}) begin
            if (tick) begin
                road1_cnt = road1_cnt - COUNT_W'(1);
                road2_cnt = road2_cnt - COUNT_W'(1);
                r1 = int'($signed(road1_cnt));
                r2 = int'($signed(road2_cnt));
                case (phase_q)
                    PH_RG: begin
                        if (r2 <= 0) begin
                            road2_cnt = {1'b0, amber_s};
                            buzz_per  = BUZZ_AMBER_PERIOD;
                            buzz_vol  = BUZZ_AMBER_VOLUME;
                            phase_q   = PH_RA;
                        end else if (r2 <= int'(green_s >> 1)) begin
                            // second half of green: warning buzz
                            buzz_per = BUZZ_WARN_PERIOD;
                            buzz_vol = BUZZ_WARN_VOLUME;
                        end
                    end
                    PH_RA: begin
                        if (r1 <= 0) begin
                            road1_cnt = {1'b0, green_s};
                            road2_cnt = {1'b0, red_s};
                            phase_q   = PH_GR;
                        end
                    end
                    PH_GR: begin
                        if (r1 <= 0) begin
                            road1_cnt = {1'b0, amber_s};
                            phase_q   = PH_AR;
                        end
                    end
                    default: begin
                        if (r1 <= 0) begin
                            road1_cnt = {1'b0, red_s};
                            road2_cnt = {1'b0, green_s};
                            buzz_per  = BUZZ_GREEN_PERIOD;
                            buzz_vol  = BUZZ_GREEN_VOLUME;
                            phase_q   = PH_RG;
                        end
                    end
                endcase
            end
        end else begin
            // init and any stray code go to load
            phase_q = PH_LOAD;
        end
    endfunction

    // lamps follow the phase, both off in init and load
    function automatic t_light_view current_view();
        t_light_view v;
        v.phase      = phase_q;
        v.road1_lamp = LAMP_OFF;
        v.road2_lamp = LAMP_OFF;
        case (phase_q)
            PH_RG: begin
                v.road1_lamp = LAMP_RED;
                v.road2_lamp = LAMP_GREEN;
            end
            PH_RA: begin
                v.road1_lamp = LAMP_RED;
                v.road2_lamp = LAMP_AMBER;
            end
            PH_GR: begin
                v.road1_lamp = LAMP_GREEN;
                v.road2_lamp = LAMP_RED;
            end
            PH_AR: begin
                v.road1_lamp = LAMP_AMBER;
                v.road2_lamp = LAMP_RED;
            end
            default: ;
        endcase
        v.road1_secs = road1_cnt;
        v.road2_secs = road2_cnt;
        v.period     = buzz_per;
        v.volume     = buzz_vol;
        return v;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // scoreboard: results first, then register writes, then new requests
    always @(posedge i_clk) begin : scoreboard
        t_light_view due;
        if (!i_rst_n) begin
            reset_model();
            lights_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (lights_due.size() == 0) begin
                    $error("result with no request waiting: phase_code %0d", i_phase_code);
                    mismatches++;
                end else begin
                    due = lights_due.pop_front();
                    check_field("phase_code", int'(due.phase), int'(i_phase_code));
                    check_field("road1_light", int'(due.road1_lamp), int'(i_road1_light));
                    check_field("road2_light", int'(due.road2_lamp), int'(i_road2_light));
                    check_field("road1_seconds", int'($signed(due.road1_secs)),
                                int'(i_road1_seconds));
                    check_field("road2_seconds", int'($signed(due.road2_secs)),
                                int'(i_road2_seconds));
                    check_field("buzz_period", int'(due.period), int'(i_buzz_period));
                    check_field("buzz_volume", int'(due.volume), int'(i_buzz_volume));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RED_TIME:   red_s   = i_cfg_data;
                    CFG_GREEN_TIME: green_s = i_cfg_data;
                    CFG_AMBER_TIME: amber_s = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                take_step(i_second_tick);
                lights_due.push_back(current_view());
            end
        end
        pending = lights_due.size();
    end

endmodule

### verif/tb_two_road_light_sequencer_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_road_light_sequencer_core: testbench of the two-road light sequencer
// Walks the block through init, load and a full lamp cycle at the reset times,
// then runs batches of random ticks under many time settings, extremes and
// countdown wrap included, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_two_road_light_sequencer_core
    import trls_pkg::*;
();

    localparam int RANDOM_STEPS = 1550;
    localparam int CYCLE_LIMIT  = 300000;
    // init with a tick, load without, then a lamp cycle with a few held steps
    localparam logic [0:23] WARMUP_TICKS = 24'b1011_0111_1011_1111_1011_1111;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_second_tick;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [2:0]                o_phase_code;
    logic [1:0]                o_road1_light;
    logic [1:0]                o_road2_light;
    logic signed [COUNT_W-1:0] o_road1_seconds;
    logic signed [COUNT_W-1:0] o_road2_seconds;
    logic [PERIOD_W-1:0]       o_buzz_period;
    logic [VOLUME_W-1:0]       o_buzz_volume;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [TIME_W-1:0]         i_cfg_data;

    int   err_count;
    int   open_count;
    int   cycle_cnt    = 0;
    bit   no_gaps      = 1'b0;
    logic result_taken = 1'b0;

    two_road_light_sequencer_core dut (.*);

    trls_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_second_tick   (i_second_tick),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_phase_code    (o_phase_code),
        .i_road1_light   (o_road1_light),
        .i_road2_light   (o_road2_light),
        .i_road1_seconds (o_road1_seconds),
        .i_road2_seconds (o_road2_seconds),
        .i_buzz_period   (o_buzz_period),
        .i_buzz_volume   (o_buzz_volume),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_err_count     (err_count),
        .o_open_count    (open_count)
    );

    // 12 ns clock
    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_two_road_light_sequencer_core: done, errors");
            $finish;
        end
    end

    // result side: a drawn stall before each result
    always @(posedge i_clk) begin
        result_taken <= o_out_valid && !i_out_stall;
    end

    initial begin : result_sink
        int stall_left;
        stall_left  = $urandom_range(0, 5);
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (result_taken) stall_left = no_gaps ? 0 : $urandom_range(0, 5);
            i_out_stall <= (stall_left > 0);
            if (stall_left > 0) stall_left--;
        end
    end

    // one request: drawn gap, then hold until taken; returns on a falling edge
    task automatic send_step(input logic tick);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_second_tick <= tick;
        @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop requests and wait until every result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        wait (open_count == 0);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_time(input t_cfg_idx idx, input logic [TIME_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin : stimulus
        int                setting_no;
        int                random_sent;
        int                batch_len;
        int                tick_pct;
        logic [TIME_W-1:0] red_v;
        logic [TIME_W-1:0] green_v;
        logic [TIME_W-1:0] amber_v;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_second_tick = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_RED_TIME;
        i_cfg_data    = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // init, load and a full lamp cycle at the reset times
        for (int k = 0; k < 24; k++) send_step(WARMUP_TICKS[k]);

        setting_no  = 0;
        random_sent = 0;
        while (random_sent < RANDOM_STEPS) begin
            settle();
            batch_len = $urandom_range(30, 120);
            tick_pct  = $urandom_range(30, 90);
            case (setting_no)
                // all zero: every phase ends on its first tick
                0: begin
                    red_v = 7'd0; green_v = 7'd0; amber_v = 7'd0;
                end
                // short red against long green and amber: countdown wraps
                1: begin
                    red_v = 7'd0; green_v = 7'd127; amber_v = 7'd127;
                    batch_len = 600;
                    tick_pct  = 95;
                end
                2: begin
                    red_v = 7'd99; green_v = 7'd99; amber_v = 7'd99;
                    tick_pct = 90;
                end
                3: begin
                    red_v = 7'd1; green_v = 7'd1; amber_v = 7'd1;
                end
                4: begin
                    red_v = 7'd127; green_v = 7'd2; amber_v = 7'd99;
                end
                default: begin
                    if ($urandom_range(0, 4) == 0) begin
                        red_v   = TIME_W'($urandom_range(0, 127));
                        green_v = TIME_W'($urandom_range(0, 127));
                        amber_v = TIME_W'($urandom_range(0, 127));
                    end else begin
                        red_v   = TIME_W'($urandom_range(0, 9));
                        green_v = TIME_W'($urandom_range(0, 9));
                        amber_v = TIME_W'($urandom_range(0, 9));
                    end
                end
            endcase
            // the unused index must leave the times alone
            if (setting_no == 0 || $urandom_range(0, 2) == 0)
                write_time(CFG_UNUSED,
                           (setting_no == 0) ? 7'h7f : TIME_W'($urandom_range(0, 127)));
            write_time(CFG_RED_TIME, red_v);
            write_time(CFG_GREEN_TIME, green_v);
            write_time(CFG_AMBER_TIME, amber_v);
            i_cfg_we <= 1'b0;

            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (batch_len) begin
                send_step($urandom_range(0, 99) < tick_pct);
                random_sent++;
            end
            setting_no++;
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_two_road_light_sequencer_core: done, clean");
        end else begin
            $display("tb_two_road_light_sequencer_core: done, errors");
        end
        $finish;
    end

endmodule
